// ===== hw/rtl/srs_pkg.sv =====
package srs_pkg;

	localparam int RAIL_COUNT = 8;
	localparam int RAIL_W     = (RAIL_COUNT > 1) ? $clog2(RAIL_COUNT) : 1;
	localparam int SWITCH_W   = 8;
	localparam int SW_IDX_W   = 3;

	// floor(x / 100) == (x * RAMP_RECIP) >> RAMP_RECIP_SH for any 32-bit x
	localparam logic [31:0] RAMP_RECIP    = 32'h51EB851F;
	localparam int          RAMP_RECIP_SH = 37;

	localparam int CAP_VOLT   = 0;
	localparam int CAP_AMP    = 1;
	localparam int CAP_SWITCH = 2;
	localparam int CAP_ACTLOW = 3;
	localparam int CAP_RAMPED = 4;

	localparam logic [2:0] ST_DOWN     = 3'd0;
	localparam logic [2:0] ST_UP       = 3'd1;
	localparam logic [2:0] ST_RAMPUP   = 3'd2;
	localparam logic [2:0] ST_RAMPDOWN = 3'd3;
	localparam logic [2:0] ST_MAX      = 3'd5;

	localparam logic [1:0] AL_NONE        = 2'd0;
	localparam logic [1:0] AL_OVERCURRENT = 2'd1;
	localparam logic [1:0] AL_UNDERVOLT   = 2'd2;
	localparam logic [1:0] AL_OVERVOLT    = 2'd3;

	localparam logic [1:0] RC_OK      = 2'd0;
	localparam logic [1:0] RC_INVALID = 2'd1;
	localparam logic [1:0] RC_NA      = 2'd2;

	localparam logic [3:0] AVG_SHIFT_RESET = 4'd4;

	typedef enum logic [2:0] {
		OP_LOAD_CAPS  = 3'd0,
		OP_SET_VOLT   = 3'd1,
		OP_SET_AMP    = 3'd2,
		OP_ON         = 3'd3,
		OP_OFF        = 3'd4,
		OP_CHECK      = 3'd5,
		OP_SET_STATUS = 3'd6,
		OP_READ       = 3'd7
	} op_t;

	typedef struct packed {
		logic [4:0]  caps;
		logic [15:0] low;
		logic [15:0] high;
		logic [15:0] amp;
		logic [2:0]  status;
		logic [1:0]  alarm;
	} entry_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  rail;
		logic [4:0]  caps;
		logic [15:0] low;
		logic [15:0] high;
		logic [15:0] amp;
		logic [2:0]  new_status;
		logic        force_off;
	} cmd_t;

	typedef struct packed {
		logic [1:0]          code;
		logic [2:0]          status;
		logic [1:0]          alarm;
		logic [SWITCH_W-1:0] switch_lines;
		logic [15:0]         low;
		logic [15:0]         high;
		logic [15:0]         amp;
		logic [4:0]          caps;
	} result_t;

	typedef struct packed {
		logic                wr_en;
		logic [RAIL_W-1:0]   addr;
		entry_t              entry;
		logic [SWITCH_W-1:0] switch_lines;
	} upd_t;

endpackage

// ===== hw/rtl/supply_rail_supervisor_core.sv =====
// Supervisor for eight supply rails held in a small rail table with a
// registered read. Each command beat goes through these steps from acceptance to its
// result: a table read at the accepting edge (with the sums shifted by
// average_shift), a stage for the divide-by-100 reciprocal multiply used by
// ramped rails, and a read-modify-write that updates the entry and loads the
// result register.
// A new command is taken once the previous one has written back, so the
// block does not overlap commands; a waiting result does not hold off the
// next command, only its own write-back. No clearing pass follows reset:
// per-entry valid bits make unwritten rails read as reset.
// average_shift is written through the cfg channel, which is always ready.
module supply_rail_supervisor_core (
	input  logic                          clk,
	input  logic                          arst_n,

	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [3:0]                    cfg_data,

	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    opcode,
	input  logic [3:0]                    rail,
	input  logic [4:0]                    caps,
	input  logic [15:0]                   volt_low_limit,
	input  logic [15:0]                   volt_high_limit,
	input  logic [15:0]                   amp_limit,
	input  logic [2:0]                    new_status,
	input  logic                          force_req,
	input  logic [31:0]                   voltage_sum,
	input  logic [31:0]                   current_sum,

	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_code,
	output logic [2:0]                    rail_status,
	output logic [1:0]                    rail_alarm,
	output logic [srs_pkg::SWITCH_W-1:0]  switch_lines,
	output logic [15:0]                   read_low_limit,
	output logic [15:0]                   read_high_limit,
	output logic [15:0]                   read_amp_limit,
	output logic [4:0]                    read_caps
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_WB
	} state_t;

	state_t                        state_q;
	logic [3:0]                    shift_q;
	srs_pkg::cmd_t                 cmd_q;
	logic [31:0]                   volt_avg_q;
	logic [31:0]                   amp_avg_q;
	logic [63:0]                   volt_prod_s2;
	logic [srs_pkg::SWITCH_W-1:0]  switch_q;
	logic                          out_valid_q;
	srs_pkg::result_t              res_q;

	logic                          in_accept;
	logic                          slot_free;
	logic                          wb_go;
	srs_pkg::entry_t               rd_entry;
	srs_pkg::upd_t                 upd;
	srs_pkg::result_t              res;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign wb_go     = (state_q == S_WB) && slot_free;

	srs_rail_mem u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_accept),
		.rd_addr  (rail[srs_pkg::RAIL_W-1:0]),
		.rd_entry (rd_entry),
		.wr_en    (wb_go && upd.wr_en),
		.wr_addr  (upd.addr),
		.wr_entry (upd.entry)
	);

	srs_update u_upd (
		.cmd        (cmd_q),
		.entry      (rd_entry),
		.volt_avg   (volt_avg_q),
		.amp_avg    (amp_avg_q),
		.volt_prod  (volt_prod_s2),
		.switch_cur (switch_q),
		.upd        (upd),
		.res        (res)
	);

	// command and averaged sums, captured with the beat
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q.op         <= srs_pkg::op_t'(opcode);
			cmd_q.rail       <= rail;
			cmd_q.caps       <= caps;
			cmd_q.low        <= volt_low_limit;
			cmd_q.high       <= volt_high_limit;
			cmd_q.amp        <= amp_limit;
			cmd_q.new_status <= new_status;
			cmd_q.force_off  <= force_req;
			volt_avg_q       <= voltage_sum >> shift_q;
			amp_avg_q        <= current_sum >> shift_q;
		end
		if (state_q == S_MUL) begin
			volt_prod_s2 <= {32'b0, volt_avg_q} * {32'b0, srs_pkg::RAMP_RECIP};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			shift_q     <= srs_pkg::AVG_SHIFT_RESET;
			switch_q    <= '0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				shift_q <= cfg_data;
			end
			if (wb_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					// hold until the result register can take the beat
					if (slot_free) begin
						switch_q    <= upd.switch_lines;
						res_q       <= res;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign result_code     = res_q.code;
	assign rail_status     = res_q.status;
	assign rail_alarm      = res_q.alarm;
	assign switch_lines    = res_q.switch_lines;
	assign read_low_limit  = res_q.low;
	assign read_high_limit = res_q.high;
	assign read_amp_limit  = res_q.amp;
	assign read_caps       = res_q.caps;

endmodule

// ===== hw/rtl/srs_rail_mem.sv =====
module srs_rail_mem (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [srs_pkg::RAIL_W-1:0] rd_addr,
	output srs_pkg::entry_t           rd_entry,
	input  logic                      wr_en,
	input  logic [srs_pkg::RAIL_W-1:0] wr_addr,
	input  srs_pkg::entry_t           wr_entry
);

	srs_pkg::entry_t                      mem_q [srs_pkg::RAIL_COUNT];
	logic [srs_pkg::RAIL_COUNT-1:0]       valid_q;
	srs_pkg::entry_t                      rd_data_q;
	logic                                 rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// an entry never written reads as its reset value: all zero, down, no alarm
	assign rd_entry = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/srs_update.sv =====
module srs_update (
	input  srs_pkg::cmd_t                  cmd,
	input  srs_pkg::entry_t                entry,
	input  logic [31:0]                    volt_avg,
	input  logic [31:0]                    amp_avg,
	input  logic [63:0]                    volt_prod,
	input  logic [srs_pkg::SWITCH_W-1:0]   switch_cur,
	output srs_pkg::upd_t                  upd,
	output srs_pkg::result_t               res
);

	localparam int SW_BITS = srs_pkg::SWITCH_W;

	function automatic logic [15:0] sat16(input logic [31:0] v);
		sat16 = (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

	logic                  rail_ok;
	logic                  ramped;
	logic                  line_ok;
	logic [SW_BITS-1:0]    line_mask;
	logic [26:0]           volt_div;
	logic [15:0]           volt_val;
	logic [15:0]           amp_val;
	logic [1:0]            alarm_chk;
	logic [1:0]            code;
	srs_pkg::entry_t       ent_n;
	logic [srs_pkg::SWITCH_W-1:0] sw_n;

	assign rail_ok   = {1'b0, cmd.rail} < 5'(srs_pkg::RAIL_COUNT);
	assign ramped    = entry.caps[srs_pkg::CAP_RAMPED];
	assign line_ok   = {1'b0, cmd.rail} < 5'(srs_pkg::SWITCH_W);
	assign line_mask = line_ok ? (SW_BITS'(1) << cmd.rail[srs_pkg::SW_IDX_W-1:0]) : '0;

	assign volt_div = volt_prod[63:srs_pkg::RAMP_RECIP_SH];
	assign volt_val = ramped ? sat16({5'b0, volt_div}) : sat16(volt_avg);
	assign amp_val  = sat16(amp_avg);

	// overcurrent first, then under- and overvoltage
	always_comb begin
		alarm_chk = srs_pkg::AL_NONE;
		if (entry.status != srs_pkg::ST_DOWN) begin
			if ((entry.caps[srs_pkg::CAP_AMP] || ramped) && amp_val >= entry.amp) begin
				alarm_chk = srs_pkg::AL_OVERCURRENT;
			end else if (entry.status == srs_pkg::ST_UP &&
			             (entry.caps[srs_pkg::CAP_VOLT] || ramped)) begin
				if (volt_val <= entry.low) begin
					alarm_chk = srs_pkg::AL_UNDERVOLT;
				end else if (volt_val >= entry.high) begin
					alarm_chk = srs_pkg::AL_OVERVOLT;
				end
			end
		end
	end

	always_comb begin
		ent_n = entry;
		sw_n  = switch_cur;
		code  = srs_pkg::RC_OK;
		case (cmd.op)
			srs_pkg::OP_LOAD_CAPS: begin
				ent_n.caps = cmd.caps;
			end
			srs_pkg::OP_SET_VOLT: begin
				if (!entry.caps[srs_pkg::CAP_VOLT] && !ramped) begin
					code = srs_pkg::RC_NA;
				end else begin
					ent_n.low  = cmd.low;
					ent_n.high = cmd.high;
				end
			end
			srs_pkg::OP_SET_AMP: begin
				if (!entry.caps[srs_pkg::CAP_AMP] && !ramped) begin
					code = srs_pkg::RC_NA;
				end else begin
					ent_n.amp = cmd.amp;
				end
			end
			srs_pkg::OP_ON: begin
				if (!entry.caps[srs_pkg::CAP_SWITCH] && !ramped) begin
					code = srs_pkg::RC_NA;
				end else if (entry.status != srs_pkg::ST_UP &&
				             entry.alarm == srs_pkg::AL_NONE) begin
					// on level is high unless the switch is active-low
					if (entry.caps[srs_pkg::CAP_ACTLOW]) begin
						sw_n = switch_cur & ~line_mask;
					end else begin
						sw_n = switch_cur | line_mask;
					end
					ent_n.status = ramped ? srs_pkg::ST_RAMPUP : srs_pkg::ST_UP;
				end
			end
			srs_pkg::OP_OFF: begin
				if (!entry.caps[srs_pkg::CAP_SWITCH] && !ramped) begin
					code = srs_pkg::RC_NA;
				end else if (entry.status != srs_pkg::ST_DOWN || cmd.force_off) begin
					if (ramped) begin
						ent_n.status = srs_pkg::ST_RAMPDOWN;
					end else begin
						if (entry.caps[srs_pkg::CAP_ACTLOW]) begin
							sw_n = switch_cur | line_mask;
						end else begin
							sw_n = switch_cur & ~line_mask;
						end
						ent_n.status = srs_pkg::ST_DOWN;
					end
				end
			end
			srs_pkg::OP_CHECK: begin
				ent_n.alarm = alarm_chk;
			end
			srs_pkg::OP_SET_STATUS: begin
				if (cmd.new_status > srs_pkg::ST_MAX) begin
					code = srs_pkg::RC_NA;
				end else begin
					ent_n.status = cmd.new_status;
				end
			end
			srs_pkg::OP_READ: begin
				ent_n = entry;
			end
			default: begin
				ent_n = entry;
			end
		endcase
	end

	always_comb begin
		upd.wr_en        = rail_ok;
		upd.addr         = cmd.rail[srs_pkg::RAIL_W-1:0];
		upd.entry        = ent_n;
		upd.switch_lines = rail_ok ? sw_n : switch_cur;
		if (rail_ok) begin
			res.code   = code;
			res.status = ent_n.status;
			res.alarm  = ent_n.alarm;
			res.low    = ent_n.low;
			res.high   = ent_n.high;
			res.amp    = ent_n.amp;
			res.caps   = ent_n.caps;
		end else begin
			res.code   = srs_pkg::RC_INVALID;
			res.status = '0;
			res.alarm  = '0;
			res.low    = '0;
			res.high   = '0;
			res.amp    = '0;
			res.caps   = '0;
		end
		res.switch_lines = upd.switch_lines;
	end

endmodule
